[hw/rtl/scio_pkg.sv]
package scio_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_HOST  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_REG,
    SRC_RAM,
    SRC_TOP,
    SRC_DSP
  } src_t;

  typedef struct packed {
    op_t         operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [2:0]  tick_mask;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       port_strobe;
    logic [1:0] port_number;
    logic [7:0] port_value;
  } out_item_t;

  typedef struct packed {
    logic ctl_wr;
    logic ctl_en;
    logic tgt_wr;
    logic tick;
    logic clr;
  } timer_ctl_t;

  localparam logic [15:0] REG_TEST     = 16'h00f0;
  localparam logic [15:0] REG_CONTROL  = 16'h00f1;
  localparam logic [15:0] REG_DSP_ADDR = 16'h00f2;
  localparam logic [15:0] REG_DSP_DATA = 16'h00f3;
  localparam logic [15:0] REG_PORT0    = 16'h00f4;
  localparam logic [15:0] REG_PORT1    = 16'h00f5;
  localparam logic [15:0] REG_PORT2    = 16'h00f6;
  localparam logic [15:0] REG_PORT3    = 16'h00f7;
  localparam logic [15:0] REG_T0_TGT   = 16'h00fa;
  localparam logic [15:0] REG_T1_TGT   = 16'h00fb;
  localparam logic [15:0] REG_T2_TGT   = 16'h00fc;
  localparam logic [15:0] REG_T0_OUT   = 16'h00fd;
  localparam logic [15:0] REG_T1_OUT   = 16'h00fe;
  localparam logic [15:0] REG_T2_OUT   = 16'h00ff;
  localparam logic [15:0] TOP_BASE     = 16'hffc0;

  localparam logic [7:0] ENV_MASK  = 8'h7f;
  localparam logic [3:0] ENV_NIBBLE = 4'h8;

  localparam logic [7:0] BOOT_ROM [64] = '{
    8'hCD, 8'hEF, 8'hBD, 8'hE8, 8'h00, 8'hC6, 8'h1D, 8'hD0,
    8'hFC, 8'h8F, 8'hAA, 8'hF4, 8'h8F, 8'hBB, 8'hF5, 8'h78,
    8'hCC, 8'hF4, 8'hD0, 8'hFB, 8'h2F, 8'h19, 8'hEB, 8'hF4,
    8'hD0, 8'hFC, 8'h7E, 8'hF4, 8'hD0, 8'h0B, 8'hE4, 8'hF5,
    8'hCB, 8'hF4, 8'hD7, 8'h00, 8'hFC, 8'hD0, 8'hF3, 8'hAB,
    8'h01, 8'h10, 8'hEF, 8'h7E, 8'hF4, 8'h10, 8'hEB, 8'hBA,
    8'hF6, 8'hDA, 8'h00, 8'hBA, 8'hF4, 8'hC4, 8'hF4, 8'hDD,
    8'h5D, 8'hD0, 8'hDB, 8'h1F, 8'h00, 8'h00, 8'hC0, 8'hFF
  };

  function automatic logic [8:0] target_of(input logic [7:0] b);
    return {(b == 8'h00), b};
  endfunction

endpackage

[hw/rtl/scio_ram.sv]
module scio_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/scio_timer.sv]
module scio_timer import scio_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  timer_ctl_t ctl,
  input  logic [7:0] data,
  output logic [3:0] count
);

  logic       enabled;
  logic [7:0] ram_byte;
  logic [8:0] target;
  logic [8:0] stage;
  logic [8:0] stage_inc;

  assign stage_inc = stage + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled  <= 1'b0;
      ram_byte <= '0;
      target   <= '0;
      stage    <= '0;
      count    <= '0;
    end else begin
      if (ctl.ctl_wr) begin
        enabled <= ctl.ctl_en;
        if (ctl.ctl_en && !enabled) begin
          stage  <= '0;
          count  <= '0;
          target <= target_of(ram_byte);
        end
      end
      if (ctl.tgt_wr) begin
        ram_byte <= data;
        target   <= target_of(data);
      end
      if (ctl.tick && enabled) begin
        if (stage_inc >= target) begin
          stage <= '0;
          count <= count + 4'd1;
        end else begin
          stage <= stage_inc;
        end
      end
      if (ctl.clr) begin
        count <= '0;
      end
    end
  end

endmodule

[hw/rtl/sound_cpu_io_register_map_core.sv]
// The accepted beat is registered into s1_valid and then into done; result is registered together with done.
// Throughput: one beat per cycle while rst is low; the RAM, shadow and DSP arrays each read once per beat.
// busy is high only while rst is held; the receiver cannot stall, so nothing waits.
// Reset clears control state, timers, ports and the shadow/DSP valid bits; RAM is not cleared.
module sound_cpu_io_register_map_core import scio_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  cmd,
  output logic      busy,
  output logic      done,
  output out_item_t result
);

  logic        accept;
  logic        is_rd;
  logic        is_wr;
  logic        is_tick;
  logic        is_host;
  logic [15:0] a;

  logic        rom_visible;
  logic [6:0]  dsp_index;
  logic [7:0]  input_ports [4];
  logic [63:0] top_valid;
  logic [127:0] dsp_valid;

  src_t        src;
  logic [7:0]  reg_val;
  logic        ram_we;
  logic        top_we;
  logic        dsp_we;
  logic        ctl_wr;
  logic        dsp_idx_wr;
  logic [2:0]  tgt_wr;
  logic [2:0]  clr;
  logic        port_hit;

  logic [7:0]  ram_q;
  logic [7:0]  top_q;
  logic [7:0]  dsp_q;
  logic [3:0]  tcount [3];
  timer_ctl_t  tctl [3];

  logic        s1_valid;
  src_t        s1_src;
  logic [7:0]  s1_reg_val;
  logic        s1_use_boot;
  logic [5:0]  s1_top_idx;
  logic        s1_dsp_live;
  logic        s1_env;
  logic        s1_port_strobe;
  logic [1:0]  s1_port_number;
  logic [7:0]  s1_port_value;

  logic [7:0]  read_next;

  assign busy    = rst;
  assign accept  = start && !busy;
  assign a       = cmd.address;
  assign is_rd   = accept && (cmd.operation == OP_READ);
  assign is_wr   = accept && (cmd.operation == OP_WRITE);
  assign is_tick = accept && (cmd.operation == OP_TICK);
  assign is_host = accept && (cmd.operation == OP_HOST);

  always_comb begin
    src        = SRC_RAM;
    reg_val    = '0;
    ram_we     = 1'b0;
    top_we     = 1'b0;
    dsp_we     = 1'b0;
    ctl_wr     = 1'b0;
    dsp_idx_wr = 1'b0;
    tgt_wr     = '0;
    clr        = '0;
    port_hit   = 1'b0;
    if (a >= TOP_BASE) begin
      src    = SRC_TOP;
      top_we = is_wr;
    end else begin
      ram_we = is_wr;
      case (a)
        REG_TEST: begin
          src = SRC_ZERO;
        end
        REG_CONTROL: begin
          src    = SRC_ZERO;
          ctl_wr = is_wr;
        end
        REG_DSP_ADDR: begin
          dsp_idx_wr = is_wr;
        end
        REG_DSP_DATA: begin
          src    = SRC_DSP;
          ram_we = 1'b0;
          dsp_we = is_wr;
        end
        REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3: begin
          src      = SRC_REG;
          reg_val  = input_ports[a[1:0]];
          ram_we   = 1'b0;
          port_hit = is_wr;
        end
        REG_T0_TGT: begin
          src       = SRC_ZERO;
          tgt_wr[0] = is_wr;
        end
        REG_T1_TGT: begin
          src       = SRC_ZERO;
          tgt_wr[1] = is_wr;
        end
        REG_T2_TGT: begin
          src       = SRC_ZERO;
          tgt_wr[2] = is_wr;
        end
        REG_T0_OUT: begin
          src     = SRC_REG;
          reg_val = {4'h0, tcount[0]};
          ram_we  = 1'b0;
          clr[0]  = is_rd;
        end
        REG_T1_OUT: begin
          src     = SRC_REG;
          reg_val = {4'h0, tcount[1]};
          ram_we  = 1'b0;
          clr[1]  = is_rd;
        end
        REG_T2_OUT: begin
          src     = SRC_REG;
          reg_val = {4'h0, tcount[2]};
          ram_we  = 1'b0;
          clr[2]  = is_rd;
        end
        default: begin
          src = SRC_RAM;
        end
      endcase
    end
  end

  scio_ram #(.ADDR_W(16), .DATA_W(8)) u_main_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (a),
    .wdata (cmd.write_data),
    .rdata (ram_q)
  );

  scio_ram #(.ADDR_W(6), .DATA_W(8)) u_top_ram (
    .clk   (clk),
    .we    (top_we),
    .addr  (a[5:0]),
    .wdata (cmd.write_data),
    .rdata (top_q)
  );

  scio_ram #(.ADDR_W(7), .DATA_W(8)) u_dsp_ram (
    .clk   (clk),
    .we    (dsp_we),
    .addr  (dsp_index),
    .wdata (cmd.write_data),
    .rdata (dsp_q)
  );

  for (genvar i = 0; i < 3; i++) begin : g_timer
    always_comb begin
      tctl[i].ctl_wr = ctl_wr;
      tctl[i].ctl_en = cmd.write_data[i];
      tctl[i].tgt_wr = tgt_wr[i];
      tctl[i].tick   = is_tick && cmd.tick_mask[i];
      tctl[i].clr    = clr[i];
    end

    scio_timer u_timer (
      .clk   (clk),
      .rst   (rst),
      .ctl   (tctl[i]),
      .data  (cmd.write_data),
      .count (tcount[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_visible <= 1'b1;
      dsp_index   <= '0;
      top_valid   <= '0;
      dsp_valid   <= '0;
      for (int i = 0; i < 4; i++) begin
        input_ports[i] <= '0;
      end
    end else begin
      if (ctl_wr) begin
        rom_visible <= cmd.write_data[7];
        if (cmd.write_data[4]) begin
          input_ports[0] <= '0;
          input_ports[1] <= '0;
        end
        if (cmd.write_data[5]) begin
          input_ports[2] <= '0;
          input_ports[3] <= '0;
        end
      end
      if (is_host) begin
        input_ports[a[1:0]] <= cmd.write_data;
      end
      if (dsp_idx_wr) begin
        dsp_index <= cmd.write_data[6:0];
      end
      if (top_we) begin
        top_valid[a[5:0]] <= 1'b1;
      end
      if (dsp_we) begin
        dsp_valid[dsp_index] <= 1'b1;
      end
    end
  end

  // stage 1: hold the decoded beat while the arrays return data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_src         <= is_rd ? src : SRC_ZERO;
    s1_reg_val     <= reg_val;
    s1_use_boot    <= rom_visible || !top_valid[a[5:0]];
    s1_top_idx     <= a[5:0];
    s1_dsp_live    <= dsp_valid[dsp_index];
    s1_env         <= (dsp_index[3:0] == ENV_NIBBLE);
    s1_port_strobe <= port_hit;
    s1_port_number <= port_hit ? a[1:0] : 2'd0;
    s1_port_value  <= port_hit ? cmd.write_data : 8'h00;
  end

  always_comb begin
    case (s1_src)
      SRC_ZERO: read_next = '0;
      SRC_REG:  read_next = s1_reg_val;
      SRC_RAM:  read_next = ram_q;
      SRC_TOP:  read_next = s1_use_boot ? BOOT_ROM[s1_top_idx] : top_q;
      SRC_DSP: begin
        if (!s1_dsp_live) begin
          read_next = '0;
        end else if (s1_env) begin
          read_next = dsp_q & ENV_MASK;
        end else begin
          read_next = dsp_q;
        end
      end
      default:  read_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.read_data   <= read_next;
    result.port_strobe <= s1_port_strobe;
    result.port_number <= s1_port_number;
    result.port_value  <= s1_port_value;
  end

endmodule

[hw/rtl/scio_checker.sv]
module scio_checker import scio_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input in_item_t  cmd,
  input logic      done,
  input out_item_t result
);

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("beat taken without a result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result strobe without a matching beat");

  a_read_only_data: assert property (@(posedge clk) disable iff (rst)
    (done && (result.read_data != 8'h00)) |-> $past(cmd.operation == OP_READ, 2))
    else $error("read data returned for a non-read beat");

  a_port_write: assert property (@(posedge clk) disable iff (rst)
    (done && result.port_strobe) |->
      $past((cmd.operation == OP_WRITE) && (cmd.address[15:2] == 14'h003d), 2) &&
      (result.port_value == $past(cmd.write_data, 2)))
    else $error("output port strobe does not match a port write");

endmodule

bind sound_cpu_io_register_map_core scio_checker u_scio_checker (.*);

[verif/tb_top.sv]
module tb_top;
  import scio_pkg::*;

  localparam int RANDOM_ACCESSES = 900;
  localparam int STALL_LIMIT     = 300;
  localparam int DRAIN_CYCLES    = 4;

  typedef struct packed {
    op_t         op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [2:0]  mask;
    bit          fixed;
    logic [7:0]  rd;
    logic        strobe;
    logic [1:0]  pnum;
    logic [7:0]  pval;
  } access_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_item_t  cmd = '0;
  logic      busy;
  logic      done;
  out_item_t result;

  // shadow copy of the I/O map
  logic [7:0]  ram [65536];
  bit          ram_set [65536];
  logic [15:0] ram_log [$];
  logic [7:0]  shadow [64];
  logic [7:0]  dsp [128];
  logic        rom_vis;
  logic [6:0]  dsp_idx;
  logic        tmr_en [3];
  logic [8:0]  tmr_tgt [3];
  logic [8:0]  tmr_stage [3];
  logic [3:0]  tmr_out [3];
  logic [7:0]  in_ports [4];

  out_item_t bus_replies [$];
  out_item_t want;
  int        fail_count = 0;
  int        stall_cycles = 0;
  int        burst_left = 0;

  access_row_t access_table [27] = '{
    '{OP_READ,  REG_TEST,     8'h00, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_READ,  TOP_BASE,     8'h00, 3'd0, 1'b1, 8'hcd, 1'b0, 2'd0, 8'h00},
    '{OP_READ,  16'hffff,     8'h00, 3'd7, 1'b1, 8'hff, 1'b0, 2'd0, 8'h00},
    '{OP_READ,  REG_DSP_DATA, 8'h00, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_READ,  REG_T2_OUT,   8'h00, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_WRITE, REG_T0_TGT,   8'h00, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_WRITE, REG_T1_TGT,   8'h01, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_WRITE, REG_T2_TGT,   8'h02, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_HOST,  16'hffff,     8'hff, 3'd7, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_READ,  REG_PORT3,    8'h00, 3'd0, 1'b1, 8'hff, 1'b0, 2'd0, 8'h00},
    '{OP_WRITE, REG_CONTROL,  8'hb7, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_READ,  REG_PORT3,    8'h00, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_TICK,  16'hffff,     8'hff, 3'd7, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_TICK,  16'h0000,     8'h00, 3'd2, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_READ,  REG_T1_OUT,   8'h00, 3'd0, 1'b0, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_READ,  REG_T1_OUT,   8'h00, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_WRITE, REG_DSP_ADDR, 8'h88, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_WRITE, REG_DSP_DATA, 8'hff, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_READ,  REG_DSP_DATA, 8'h00, 3'd0, 1'b1, 8'h7f, 1'b0, 2'd0, 8'h00},
    '{OP_READ,  REG_DSP_ADDR, 8'h00, 3'd0, 1'b1, 8'h88, 1'b0, 2'd0, 8'h00},
    '{OP_WRITE, TOP_BASE,     8'h5a, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_WRITE, REG_CONTROL,  8'h07, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_READ,  TOP_BASE,     8'h00, 3'd0, 1'b1, 8'h5a, 1'b0, 2'd0, 8'h00},
    '{OP_WRITE, REG_PORT0,    8'h00, 3'd0, 1'b1, 8'h00, 1'b1, 2'd0, 8'h00},
    '{OP_WRITE, REG_T0_OUT,   8'h55, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_WRITE, 16'h0000,     8'ha5, 3'd0, 1'b1, 8'h00, 1'b0, 2'd0, 8'h00},
    '{OP_READ,  16'h0000,     8'h00, 3'd0, 1'b1, 8'ha5, 1'b0, 2'd0, 8'h00}
  };

  sound_cpu_io_register_map_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_map();
    for (int i = 0; i < 64; i++) shadow[i] = BOOT_ROM[i];
    for (int i = 0; i < 128; i++) dsp[i] = 8'h00;
    for (int i = 0; i < 3; i++) begin
      tmr_en[i] = 1'b0;
      tmr_tgt[i] = 9'd0;
      tmr_stage[i] = 9'd0;
      tmr_out[i] = 4'd0;
    end
    for (int i = 0; i < 4; i++) in_ports[i] = 8'h00;
    rom_vis = 1'b1;
    dsp_idx = 7'd0;
  endfunction

  function automatic logic [8:0] reload_of(logic [7:0] b);
    return (b == 8'h00) ? 9'h100 : {1'b0, b};
  endfunction

  function automatic void store_ram(logic [15:0] a, logic [7:0] d);
    if (!ram_set[a]) ram_log.push_back(a);
    ram_set[a] = 1'b1;
    ram[a] = d;
  endfunction

  function automatic bit hits_ram(logic [15:0] a);
    case (a)
      REG_TEST, REG_CONTROL, REG_DSP_DATA, REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3,
      REG_T0_TGT, REG_T1_TGT, REG_T2_TGT, REG_T0_OUT, REG_T1_OUT, REG_T2_OUT: return 1'b0;
      default: return a < TOP_BASE;
    endcase
  endfunction

  function automatic out_item_t decode_access(in_item_t c);
    out_item_t r;
    logic [15:0] a;
    logic [7:0] d;
    int t;
    r = '0;
    a = c.address;
    d = c.write_data;
    case (c.operation)
      OP_READ: begin
        case (a)
          REG_TEST, REG_CONTROL, REG_T0_TGT, REG_T1_TGT, REG_T2_TGT: r.read_data = 8'h00;
          REG_DSP_DATA: begin
            r.read_data = dsp[dsp_idx];
            if (dsp_idx[3:0] == ENV_NIBBLE) r.read_data &= ENV_MASK;
          end
          REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3: r.read_data = in_ports[a[1:0]];
          REG_T0_OUT, REG_T1_OUT, REG_T2_OUT: begin
            t = int'(a - REG_T0_OUT);
            r.read_data = {4'h0, tmr_out[t]};
            tmr_out[t] = 4'd0;
          end
          default: begin
            if (a >= TOP_BASE) r.read_data = rom_vis ? BOOT_ROM[a[5:0]] : shadow[a[5:0]];
            else r.read_data = ram[a];
          end
        endcase
      end
      OP_WRITE: begin
        case (a)
          REG_CONTROL: begin
            for (int i = 0; i < 3; i++) begin
              if (d[i] && !tmr_en[i]) begin
                tmr_stage[i] = 9'd0;
                tmr_out[i] = 4'd0;
                tmr_tgt[i] = reload_of(ram[REG_T0_TGT + 16'(i)]);
              end
              tmr_en[i] = d[i];
            end
            if (d[4]) begin
              in_ports[0] = 8'h00;
              in_ports[1] = 8'h00;
            end
            if (d[5]) begin
              in_ports[2] = 8'h00;
              in_ports[3] = 8'h00;
            end
            rom_vis = d[7];
            store_ram(a, d);
          end
          REG_DSP_ADDR: begin
            store_ram(a, d);
            dsp_idx = d[6:0];
          end
          REG_DSP_DATA: dsp[dsp_idx] = d;
          REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3: begin
            r.port_strobe = 1'b1;
            r.port_number = a[1:0];
            r.port_value = d;
          end
          REG_T0_TGT, REG_T1_TGT, REG_T2_TGT: begin
            store_ram(a, d);
            t = int'(a - REG_T0_TGT);
            tmr_tgt[t] = reload_of(d);
          end
          REG_T0_OUT, REG_T1_OUT, REG_T2_OUT: ;
          default: begin
            if (a >= TOP_BASE) shadow[a[5:0]] = d;
            else store_ram(a, d);
          end
        endcase
      end
      OP_TICK: begin
        for (int i = 0; i < 3; i++) begin
          if (c.tick_mask[i] && tmr_en[i]) begin
            tmr_stage[i] = tmr_stage[i] + 9'd1;
            if (tmr_stage[i] >= tmr_tgt[i]) begin
              tmr_stage[i] = 9'd0;
              tmr_out[i] = tmr_out[i] + 4'd1;
            end
          end
        end
      end
      default: in_ports[a[1:0]] = d;
    endcase
    return r;
  endfunction

  function automatic in_item_t random_access();
    in_item_t c;
    int k;
    c.operation = OP_READ;
    c.address = 16'($urandom);
    c.write_data = 8'($urandom);
    c.tick_mask = 3'($urandom);
    k = $urandom_range(0, 99);
    if (k < 12) begin
      c.address = ram_log[$urandom_range(0, ram_log.size() - 1)];
    end else if (k < 24) begin
      c.address = REG_TEST + 16'($urandom_range(0, 15));
    end else if (k < 30) begin
      c.address = TOP_BASE + 16'($urandom_range(0, 63));
    end else if (k < 38) begin
      c.operation = OP_WRITE;
    end else if (k < 50) begin
      c.operation = OP_WRITE;
      c.address = REG_TEST + 16'($urandom_range(0, 15));
    end else if (k < 55) begin
      c.operation = OP_WRITE;
      c.address = TOP_BASE + 16'($urandom_range(0, 63));
    end else if (k < 58) begin
      c.operation = OP_WRITE;
      c.address = REG_CONTROL;
    end else if (k < 82) begin
      c.operation = OP_TICK;
    end else begin
      c.operation = OP_HOST;
    end
    // keep targets short so the timer outputs move
    if (c.operation == OP_WRITE && c.address >= REG_T0_TGT && c.address <= REG_T2_TGT &&
        $urandom_range(0, 5) != 0)
      c.write_data = 8'($urandom_range(0, 6));
    if (c.operation == OP_WRITE && c.address == REG_CONTROL && $urandom_range(0, 3) != 0)
      c.write_data[2:0] = 3'b111;
    // never read a RAM byte that has not been written
    if (c.operation == OP_READ && hits_ram(c.address) && !ram_set[c.address])
      c.address = ram_log[$urandom_range(0, ram_log.size() - 1)];
    return c;
  endfunction

  task automatic put_access(in_item_t c, bit fixed, out_item_t fixed_reply);
    out_item_t r;
    start <= 1'b1;
    cmd <= c;
    @(posedge clk iff !busy);
    r = decode_access(c);
    bus_replies.push_back(fixed ? fixed_reply : r);
  endtask

  task automatic compare_field(string name, logic [7:0] exp, logic [7:0] got);
    if (got !== exp) begin
      $error("%s: expected %0h, got %0h", name, exp, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (bus_replies.size() == 0) begin
        $error("beat with no access outstanding");
        fail_count++;
      end else begin
        want = bus_replies.pop_front();
        compare_field("read_data", want.read_data, result.read_data);
        compare_field("port_strobe", 8'(want.port_strobe), 8'(result.port_strobe));
        compare_field("port_number", 8'(want.port_number), 8'(result.port_number));
        compare_field("port_value", want.port_value, result.port_value);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    in_item_t c;
    out_item_t fixed_reply;
    clear_map();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (access_table[n]) begin
      c.operation = access_table[n].op;
      c.address = access_table[n].addr;
      c.write_data = access_table[n].data;
      c.tick_mask = access_table[n].mask;
      fixed_reply.read_data = access_table[n].rd;
      fixed_reply.port_strobe = access_table[n].strobe;
      fixed_reply.port_number = access_table[n].pnum;
      fixed_reply.port_value = access_table[n].pval;
      put_access(c, access_table[n].fixed, fixed_reply);
    end

    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      if (n == RANDOM_ACCESSES / 2) begin
        // hold off until every outstanding beat has returned
        start <= 1'b0;
        while (bus_replies.size() != 0) @(posedge clk);
        burst_left = 0;
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
      put_access(random_access(), 1'b0, '0);
    end

    start <= 1'b0;
    while (bus_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && bus_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
